### hdl/ecst_pkg.sv
// ecst_pkg: types, codes and constants shared by the error code set table
// no dependencies; imported by ecst_slot_mem, ecst_ctrl and the top level
`default_nettype none

package ecst_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int CODE_BITS_DEF = 16;
   localparam int MAX_RESULTS   = 16;

   localparam int OP_W     = 2;
   localparam int CODE_W   = 16;
   localparam int LIMIT_W  = 5;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST     = 2'd2;
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED = 3'd0,
      STAT_PRESENT  = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_REMOVED  = 3'd3,
      STAT_NOTFOUND = 3'd4,
      STAT_ENTRY    = 3'd5,
      STAT_EMPTY    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_TEST
   } state_type;

   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } mem_cmd_type;

   typedef struct packed {
      status_type          status;
      logic [CODE_W-1:0]   entry_code;
      logic [LIMIT_W-1:0]  count;
      logic [TIME_W-1:0]   change_time;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/ecst_slot_mem.sv
// ecst_slot_mem: slot store, one write and one registered read per cycle
// occupancy held as valid bits cleared at reset; uses ecst_pkg
`default_nettype none

module ecst_slot_mem #(
   parameter int SLOTS     = ecst_pkg::SLOTS_DEF,
   parameter int CODE_BITS = ecst_pkg::CODE_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  ecst_pkg::mem_cmd_type        cmd,
   input  wire  [$clog2(SLOTS)-1:0]     rd_addr,
   input  wire  [$clog2(SLOTS)-1:0]     wr_addr,
   input  wire  [CODE_BITS-1:0]         wr_data,
   output logic [CODE_BITS-1:0]         rd_data_ff,
   output logic                         rd_vld_ff
);
   import ecst_pkg::*;

   logic [CODE_BITS-1:0] mem_ff [SLOTS];
   logic [SLOTS-1:0]     valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (cmd.clr) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         if (cmd.rd) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

endmodule

`default_nettype wire

### hdl/ecst_ctrl.sv
// ecst_ctrl: sequencer stepping one shared comparator over the slots
// drives ecst_slot_mem and builds each response; uses ecst_pkg
`default_nettype none

module ecst_ctrl #(
   parameter int SLOTS     = ecst_pkg::SLOTS_DEF,
   parameter int CODE_BITS = ecst_pkg::CODE_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  [ecst_pkg::OP_W-1:0]       req_op,
   input  wire  [ecst_pkg::CODE_W-1:0]     req_code,
   input  wire  [ecst_pkg::LIMIT_W-1:0]    req_list_limit,
   input  wire  [ecst_pkg::TIME_W-1:0]     req_now_time,
   output ecst_pkg::mem_cmd_type           mem_cmd,
   output logic [$clog2(SLOTS)-1:0]        mem_rd_addr,
   output logic [$clog2(SLOTS)-1:0]        mem_wr_addr,
   output logic [CODE_BITS-1:0]            mem_wr_data,
   input  wire  [CODE_BITS-1:0]            mem_rd_data,
   input  wire                             mem_rd_vld,
   output logic                            rsp_strobe,
   output ecst_pkg::rsp_type               rsp
);
   import ecst_pkg::*;

   localparam int IDXW = $clog2(SLOTS);
   localparam int OCCW = $clog2(SLOTS + 1);
   localparam int CMPW = (OCCW > LIMIT_W) ? OCCW : LIMIT_W;
   localparam int WIDE = (CODE_BITS > CODE_W) ? CODE_BITS : CODE_W;
   localparam logic [IDXW-1:0]    LAST_IDX = IDXW'(SLOTS - 1);
   localparam logic [LIMIT_W-1:0] MAX_LIM  = LIMIT_W'(MAX_RESULTS);

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [LIMIT_W-1:0]    total_ff, total_in;
   logic [LIMIT_W-1:0]    sent_ff, sent_in;
   logic [IDXW-1:0]       idx_ff, idx_in;
   logic                  free_found_ff, free_found_in;
   logic [IDXW-1:0]       free_idx_ff, free_idx_in;
   logic [TIME_W-1:0]     stamp_ff, stamp_in;
   logic [OCCW-1:0]       occ_ff, occ_in;

   logic [WIDE-1:0]       req_wide;
   logic [WIDE-1:0]       slot_wide;
   logic [WIDE-1:0]       code_wide;
   logic [CODE_BITS-1:0]  req_code_ext;
   logic [CODE_W-1:0]     slot_code_out;
   logic [CODE_W-1:0]     code_out;
   logic [LIMIT_W-1:0]    lim_sat;
   logic [CMPW-1:0]       occ_ext;
   logic [CMPW-1:0]       lim_ext;
   logic [LIMIT_W-1:0]    total_calc;
   logic                  accept;
   logic                  immediate;
   logic                  hit;
   logic                  at_end;
   logic [LIMIT_W-1:0]    sent_inc;
   logic                  list_last;
   logic                  free_any;
   logic [IDXW-1:0]       take_free;
   logic                  finish;

   // width adaptation and per-slot decisions
   always_comb begin
      req_wide      = WIDE'(req_code);
      req_code_ext  = req_wide[CODE_BITS-1:0];
      slot_wide     = WIDE'(mem_rd_data);
      slot_code_out = slot_wide[CODE_W-1:0];
      code_wide     = WIDE'(code_ff);
      code_out      = code_wide[CODE_W-1:0];

      lim_sat    = (req_list_limit > MAX_LIM) ? MAX_LIM : req_list_limit;
      occ_ext    = CMPW'(occ_ff);
      lim_ext    = CMPW'(lim_sat);
      total_calc = (occ_ext < lim_ext) ? occ_ext[LIMIT_W-1:0] : lim_sat;

      accept    = start && (state_ff == S_IDLE);
      immediate = 1'b0;
      case (req_op)
         OP_INSERT, OP_REMOVE: immediate = (req_code_ext == '0);
         OP_LIST:              immediate = (total_calc == '0);
         default:              immediate = 1'b1;
      endcase

      hit       = mem_rd_vld && (mem_rd_data == code_ff);
      at_end    = (idx_ff == LAST_IDX);
      sent_inc  = sent_ff + LIMIT_W'(1);
      list_last = (sent_inc == total_ff);
      free_any  = free_found_ff || !mem_rd_vld;
      take_free = free_found_ff ? free_idx_ff : idx_ff;

      finish = 1'b1;
      case (op_ff)
         OP_INSERT, OP_REMOVE: finish = hit || at_end;
         OP_LIST:              finish = (mem_rd_vld && list_last) || at_end;
         default:              finish = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && !immediate) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_TEST;
         S_TEST: begin
            state_in = finish ? S_IDLE : S_FETCH;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      code_in       = code_ff;
      now_in        = now_ff;
      total_in      = total_ff;
      sent_in       = sent_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      stamp_in      = stamp_ff;
      occ_in        = occ_ff;

      mem_cmd     = '0;
      mem_rd_addr = idx_ff;
      mem_wr_addr = idx_ff;
      mem_wr_data = code_ff;

      rsp_strobe      = 1'b0;
      rsp.status      = STAT_EMPTY;
      rsp.entry_code  = '0;
      rsp.count       = '0;
      rsp.last        = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               code_in       = req_code_ext;
               now_in        = req_now_time;
               total_in      = total_calc;
               sent_in       = '0;
               idx_in        = '0;
               free_found_in = 1'b0;
               rsp_strobe    = immediate;
            end
         end
         S_FETCH: begin
            mem_cmd.rd = 1'b1;
         end
         S_TEST: begin
            case (op_ff)
               OP_INSERT: begin
                  if (hit) begin
                     rsp_strobe     = 1'b1;
                     rsp.status     = STAT_PRESENT;
                     rsp.entry_code = code_out;
                  end else begin
                     if (!free_found_ff && !mem_rd_vld) begin
                        free_found_in = 1'b1;
                        free_idx_in   = idx_ff;
                     end
                     if (at_end) begin
                        rsp_strobe     = 1'b1;
                        rsp.entry_code = code_out;
                        if (free_any) begin
                           mem_cmd.wr  = 1'b1;
                           mem_wr_addr = take_free;
                           stamp_in    = now_ff;
                           occ_in      = occ_ff + OCCW'(1);
                           rsp.status  = STAT_INSERTED;
                        end else begin
                           rsp.status  = STAT_FULL;
                        end
                     end
                  end
               end
               OP_REMOVE: begin
                  if (hit) begin
                     mem_cmd.clr    = 1'b1;
                     stamp_in       = now_ff;
                     occ_in         = occ_ff - OCCW'(1);
                     rsp_strobe     = 1'b1;
                     rsp.status     = STAT_REMOVED;
                     rsp.entry_code = code_out;
                  end else if (at_end) begin
                     rsp_strobe     = 1'b1;
                     rsp.status     = STAT_NOTFOUND;
                     rsp.entry_code = code_out;
                  end
               end
               OP_LIST: begin
                  if (mem_rd_vld) begin
                     rsp_strobe     = 1'b1;
                     rsp.status     = STAT_ENTRY;
                     rsp.entry_code = slot_code_out;
                     rsp.count      = sent_inc;
                     rsp.last       = list_last;
                     sent_in        = sent_inc;
                  end
               end
               default: begin
                  rsp_strobe = 1'b0;
               end
            endcase
            if (!finish) begin
               idx_in = idx_ff + IDXW'(1);
            end
         end
         default: begin
            rsp_strobe = 1'b0;
         end
      endcase

      rsp.change_time = stamp_in;
      busy            = (state_ff != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stamp_ff <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         stamp_ff <= stamp_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      code_ff       <= code_in;
      now_ff        <= now_in;
      total_ff      <= total_in;
      sent_ff       <= sent_in;
      idx_ff        <= idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

endmodule

`default_nettype wire

### hdl/error_code_set_table_unit.sv
// error_code_set_table_unit: set of nonzero error codes with insert, remove and list
// zero code, reserved op or empty list answer in the cycle after the request;
// otherwise each slot scanned takes a fetch state then a test state (one read port,
// one shared comparator), over the slots in order until the op's last response
// one request at a time while busy; list entries come one per scanned occupied slot
// reset clears every slot and the change time at once; responses cannot be stalled
`default_nettype none

module error_code_set_table_unit #(
   parameter int SLOTS     = ecst_pkg::SLOTS_DEF,
   parameter int CODE_BITS = ecst_pkg::CODE_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  [ecst_pkg::OP_W-1:0]       req_op,
   input  wire  [ecst_pkg::CODE_W-1:0]     req_code,
   input  wire  [ecst_pkg::LIMIT_W-1:0]    req_list_limit,
   input  wire  [ecst_pkg::TIME_W-1:0]     req_now_time,
   output logic                            rsp_strobe,
   output logic [ecst_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ecst_pkg::CODE_W-1:0]     rsp_entry_code,
   output logic [ecst_pkg::LIMIT_W-1:0]    rsp_count,
   output logic [ecst_pkg::TIME_W-1:0]     rsp_change_time,
   output logic                            rsp_last
);
   import ecst_pkg::*;

   localparam int IDXW = $clog2(SLOTS);

   mem_cmd_type           mem_cmd;
   logic [IDXW-1:0]       mem_rd_addr;
   logic [IDXW-1:0]       mem_wr_addr;
   logic [CODE_BITS-1:0]  mem_wr_data;
   logic [CODE_BITS-1:0]  mem_rd_data;
   logic                  mem_rd_vld;
   logic                  rsp_stb_in;
   rsp_type               rsp_in;
   logic                  rsp_stb_ff;
   rsp_type               rsp_ff;

   ecst_slot_mem #(
      .SLOTS     (SLOTS),
      .CODE_BITS (CODE_BITS)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .cmd        (mem_cmd),
      .rd_addr    (mem_rd_addr),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_data_ff (mem_rd_data),
      .rd_vld_ff  (mem_rd_vld)
   );

   ecst_ctrl #(
      .SLOTS     (SLOTS),
      .CODE_BITS (CODE_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_code       (req_code),
      .req_list_limit (req_list_limit),
      .req_now_time   (req_now_time),
      .mem_cmd        (mem_cmd),
      .mem_rd_addr    (mem_rd_addr),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_data    (mem_rd_data),
      .mem_rd_vld     (mem_rd_vld),
      .rsp_strobe     (rsp_stb_in),
      .rsp            (rsp_in)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_stb_ff <= 1'b0;
      end else begin
         rsp_stb_ff <= rsp_stb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_stb_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe      = rsp_stb_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_entry_code  = rsp_ff.entry_code;
   assign rsp_count       = rsp_ff.count;
   assign rsp_change_time = rsp_ff.change_time;
   assign rsp_last        = rsp_ff.last;

endmodule

`default_nettype wire

### dv/error_code_set_table_unit_test.sv
`timescale 1ns / 1ps
// error_code_set_table_unit_test: self-checking testbench for the error code set table
// predicts every response from its own copy of the slots and change time, checks
// each strobed response in order; depends on ecst_pkg and error_code_set_table_unit
module error_code_set_table_unit_test;
   import ecst_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 2 * SLOTS_DEF + 8;
   localparam int POOL_SIZE   = 24;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_op;
   logic [CODE_W-1:0]    req_code;
   logic [LIMIT_W-1:0]   req_list_limit;
   logic [TIME_W-1:0]    req_now_time;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [CODE_W-1:0]    rsp_entry_code;
   logic [LIMIT_W-1:0]   rsp_count;
   logic [TIME_W-1:0]    rsp_change_time;
   logic                 rsp_last;

   logic [CODE_W-1:0]    slot_model [SLOTS_DEF];
   logic [TIME_W-1:0]    stamp_model;
   logic [CODE_W-1:0]    code_pool [POOL_SIZE];
   rsp_type              answers_due [$];
   rsp_type              due;
   int                   status_tally [7];
   int                   errors = 0;
   int                   requests_sent = 0;
   int                   responses_seen = 0;
   int                   quiet_cycles = 0;
   bit                   gaps_on = 1'b1;

   error_code_set_table_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_code        (req_code),
      .req_list_limit  (req_list_limit),
      .req_now_time    (req_now_time),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_code  (rsp_entry_code),
      .rsp_count       (rsp_count),
      .rsp_change_time (rsp_change_time),
      .rsp_last        (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void push_answer(input status_type st, input logic [CODE_W-1:0] code,
                                       input logic [LIMIT_W-1:0] cnt, input logic last_flag);
      rsp_type ans;
      ans.status      = st;
      ans.entry_code  = code;
      ans.count       = cnt;
      ans.change_time = stamp_model;
      ans.last        = last_flag;
      answers_due.push_back(ans);
   endfunction

   function automatic void predict_table_answers(input logic [OP_W-1:0] op,
                                                 input logic [CODE_W-1:0] code,
                                                 input logic [LIMIT_W-1:0] limit,
                                                 input logic [TIME_W-1:0] now);
      int slot;
      int hit;
      int total;
      int n;
      int lim;
      if (op == OP_INSERT || op == OP_REMOVE) begin
         if (code == '0) begin
            push_answer(STAT_EMPTY, '0, '0, 1'b1);
            return;
         end
         hit = -1;
         for (slot = 0; slot < SLOTS_DEF; slot++)
            if (hit < 0 && slot_model[slot] == code) hit = slot;
         if (hit >= 0) begin
            if (op == OP_INSERT) begin
               push_answer(STAT_PRESENT, code, '0, 1'b1);
            end else begin
               slot_model[hit] = '0;
               stamp_model = now;
               push_answer(STAT_REMOVED, code, '0, 1'b1);
            end
            return;
         end
         if (op == OP_REMOVE) begin
            push_answer(STAT_NOTFOUND, code, '0, 1'b1);
            return;
         end
         for (slot = 0; slot < SLOTS_DEF; slot++)
            if (hit < 0 && slot_model[slot] == '0) hit = slot;
         if (hit >= 0) begin
            slot_model[hit] = code;
            stamp_model = now;
            push_answer(STAT_INSERTED, code, '0, 1'b1);
         end else begin
            push_answer(STAT_FULL, code, '0, 1'b1);
         end
      end else if (op == OP_LIST) begin
         lim = (limit > MAX_RESULTS) ? MAX_RESULTS : int'(limit);
         total = 0;
         for (slot = 0; slot < SLOTS_DEF; slot++)
            if (slot_model[slot] != '0) total++;
         if (total > lim) total = lim;
         if (total == 0) begin
            push_answer(STAT_EMPTY, '0, '0, 1'b1);
            return;
         end
         n = 0;
         for (slot = 0; slot < SLOTS_DEF; slot++) begin
            if (n < total && slot_model[slot] != '0) begin
               push_answer(STAT_ENTRY, slot_model[slot], LIMIT_W'(n + 1), n + 1 == total);
               n++;
            end
         end
      end else begin
         push_answer(STAT_EMPTY, '0, '0, 1'b1);
      end
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                               input logic [LIMIT_W-1:0] limit, input logic [TIME_W-1:0] now);
      int n;
      @(negedge clock);
      start          = 1'b1;
      req_op         = op;
      req_code       = code;
      req_list_limit = limit;
      req_now_time   = now;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_table_answers(op, code, limit, now);
      requests_sent++;
      n = gap_len();
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic pause_until_answered();
      @(negedge clock);
      start = 1'b0;
      wait (answers_due.size() == 0);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected response code", rsp_entry_code, '0);
         end else begin
            due = answers_due.pop_front();
            if (rsp_status !== due.status) report_mismatch("status", rsp_status, due.status);
            if (rsp_entry_code !== due.entry_code)
               report_mismatch("entry_code", rsp_entry_code, due.entry_code);
            if (rsp_count !== due.count) report_mismatch("count", rsp_count, due.count);
            if (rsp_change_time !== due.change_time)
               report_mismatch("change_time", rsp_change_time, due.change_time);
            if (rsp_last !== due.last) report_mismatch("last", rsp_last, due.last);
            status_tally[int'(due.status)]++;
            responses_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("error_code_set_table_unit_test: FAIL");
      $finish;
   end

   task automatic test_special_cases();
      send_request(OP_INSERT, 16'h0000, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 16'h0000, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_LIST, 16'hFFFF, 5'd16, 32'h0);
      send_request(OP_RESERVED, 16'hFFFF, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 16'hFFFF, 5'd0, 32'h1);
      send_request(OP_INSERT, 16'hFFFF, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 16'hFFFF, 5'd31, 32'h0);
      send_request(OP_INSERT, 16'h0001, 5'd0, 32'h0);
      send_request(OP_INSERT, 16'h8000, 5'd0, 32'h8000_0000);
      send_request(OP_LIST, 16'h0, 5'd0, 32'h0);
      send_request(OP_LIST, 16'h0, 5'd31, 32'h0);
      send_request(OP_LIST, 16'h0, 5'd1, 32'h0);
      send_request(OP_REMOVE, 16'h0001, 5'd0, 32'h1234_5678);
      send_request(OP_INSERT, 16'h5A5A, 5'd0, 32'hA5A5_A5A5);
      send_request(OP_LIST, 16'h0, 5'd16, 32'h0);
      send_request(OP_REMOVE, 16'h0001, 5'd0, 32'h0);
      send_request(OP_RESERVED, 16'h0000, 5'd0, 32'h0);
      pause_until_answered();
   endtask

   task automatic test_pool_churn(input int items);
      int i;
      int r;
      logic [CODE_W-1:0] c;
      for (i = 0; i < POOL_SIZE; i++) code_pool[i] = CODE_W'($urandom_range(1, 65535));
      for (i = 0; i < items; i++) begin
         gaps_on = ((i / 60) % 3) != 2;
         r = $urandom_range(0, 99);
         c = code_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (r < 40) send_request(OP_INSERT, c, LIMIT_W'($urandom()), $urandom());
         else if (r < 70) send_request(OP_REMOVE, c, LIMIT_W'($urandom()), $urandom());
         else if (r < 88) send_request(OP_LIST, CODE_W'($urandom()),
                                       LIMIT_W'($urandom_range(0, 31)), $urandom());
         else if (r < 93) send_request(OP_W'($urandom_range(0, 1)), '0,
                                       LIMIT_W'($urandom()), $urandom());
         else if (r < 96) send_request(OP_RESERVED, CODE_W'($urandom()),
                                       LIMIT_W'($urandom()), $urandom());
         else send_request(OP_W'($urandom_range(0, 1)), CODE_W'($urandom()),
                           LIMIT_W'($urandom()), $urandom());
         if ($urandom_range(0, 99) < 2) pause_until_answered();
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_fill_and_drain();
      int k;
      int j;
      int tmp;
      int order [SLOTS_DEF];
      for (k = 0; k < 20; k++)
         send_request(OP_INSERT, CODE_W'($urandom_range(1, 65535)), LIMIT_W'($urandom()),
                      $urandom());
      send_request(OP_INSERT, slot_model[$urandom_range(0, SLOTS_DEF - 1)], '0, $urandom());
      send_request(OP_LIST, CODE_W'($urandom()), 5'd16, $urandom());
      send_request(OP_LIST, CODE_W'($urandom()), LIMIT_W'($urandom_range(17, 31)), $urandom());
      pause_until_answered();
      for (k = 0; k < SLOTS_DEF; k++) order[k] = k;
      for (k = SLOTS_DEF - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (k = 0; k < SLOTS_DEF; k++) begin
         send_request(OP_REMOVE, slot_model[order[k]], LIMIT_W'($urandom()), $urandom());
         if (k % 4 == 3)
            send_request(OP_LIST, CODE_W'($urandom()), LIMIT_W'($urandom_range(0, 31)),
                         $urandom());
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = '0;
      req_code       = '0;
      req_list_limit = '0;
      req_now_time   = '0;
      stamp_model    = '0;
      for (int s = 0; s < SLOTS_DEF; s++) slot_model[s] = '0;
      for (int s = 0; s < 7; s++) status_tally[s] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_cases();
      test_pool_churn(200);
      test_fill_and_drain();
      test_fill_and_drain();
      test_pool_churn(170);

      @(negedge clock);
      start = 1'b0;
      wait (answers_due.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d responses over insert, remove, list and ignored ops",
               requests_sent, responses_seen);
      $display("inserted %0d present %0d full %0d removed %0d not found %0d entries %0d empty %0d",
               status_tally[int'(STAT_INSERTED)], status_tally[int'(STAT_PRESENT)],
               status_tally[int'(STAT_FULL)], status_tally[int'(STAT_REMOVED)],
               status_tally[int'(STAT_NOTFOUND)], status_tally[int'(STAT_ENTRY)],
               status_tally[int'(STAT_EMPTY)]);
      if (errors == 0) begin
         $display("error_code_set_table_unit_test: PASS");
      end else begin
         $display("error_code_set_table_unit_test: FAIL");
      end
      $finish;
   end

endmodule
